### rtl/xcic_pkg.sv
`default_nettype none

package xcic_pkg;

    // Width of the pixel count register and of the warm-up counter.
    localparam int COUNT_BITS = 24;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int PIXEL_W = 24;

    localparam logic [31:0] KEY_SEED_RESET = 32'd123456789;
    localparam logic [31:0] SECRET_RESET = 32'd0;
    localparam logic [COUNT_BITS-1:0] PIXEL_COUNT_RESET = COUNT_BITS'(1);

    // xorshift32 shift amounts.
    localparam int SHIFT_A = 13;
    localparam int SHIFT_B = 17;
    localparam int SHIFT_C = 5;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_KEY_SEED     = 2'd0,
        REG_SECRET_VALUE = 2'd1,
        REG_PIXEL_COUNT  = 2'd2,
        REG_DECRYPT_MODE = 2'd3
    } cfg_index_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_WARM = 1'b1
    } state_t;

    typedef struct packed {
        logic       first_pixel;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } in_pixel_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
    } out_pixel_t;

    // Commands from the sequencer to the keystream generator.
    typedef struct packed {
        logic load;
        logic advance;
    } gen_ctrl_t;

    // Status from the keystream generator back to the sequencer.
    typedef struct packed {
        logic [31:0] word;
        logic [31:0] next_word;
        logic        busy;
    } gen_stat_t;

endpackage

`default_nettype wire

### rtl/xcic_keygen.sv
`default_nettype none

// xorshift32 keystream generator with a warm-up counter. One step unit
// serves both the warm-up run and the per-pixel advance.
module xcic_keygen (
    input  wire                               clk,
    input  wire                               rst_n,
    input  xcic_pkg::gen_ctrl_t               ctrl,
    input  wire  [31:0]                       seed,
    input  wire  [xcic_pkg::COUNT_BITS-1:0]   count,
    output xcic_pkg::gen_stat_t               stat
);

    logic [31:0]                     word_reg;
    logic [31:0]                     word_next;
    logic [xcic_pkg::COUNT_BITS-1:0] cnt_reg;
    logic [xcic_pkg::COUNT_BITS-1:0] cnt_next;
    logic [31:0]                     step_a;
    logic [31:0]                     step_b;
    logic [31:0]                     step_word;

    always_comb
    begin
        step_a    = word_reg ^ (word_reg << xcic_pkg::SHIFT_A);
        step_b    = step_a ^ (step_a >> xcic_pkg::SHIFT_B);
        step_word = step_b ^ (step_b << xcic_pkg::SHIFT_C);
    end

    always_comb
    begin
        word_next = word_reg;
        cnt_next  = cnt_reg;
        priority if (ctrl.load)
        begin
            word_next = seed;
            cnt_next  = count;
        end
        else if (cnt_reg != '0)
        begin
            word_next = step_word;
            cnt_next  = cnt_reg - xcic_pkg::COUNT_BITS'(1);
        end
        else if (ctrl.advance)
        begin
            word_next = step_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            word_reg <= word_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign stat.word      = word_reg;
    assign stat.next_word = step_word;
    assign stat.busy      = (cnt_reg != '0);

endmodule

`default_nettype wire

### rtl/xor_chain_image_cipher_core.sv
// A later pixel reaches the output register in the cycle after its transaction.
// A first pixel passes through a load cycle, then one xorshift step per cycle of
// warm-up in the shared step unit, then the output cycle; the input stalls meanwhile.
// Throughput: one later pixel per cycle while out_stall is low; none enters in warm-up.
// Reset (rst_n, asynchronous, active low) restores the register defaults and clears
// the generator word, the chain pixel and the output valid flag.
`default_nettype none

module xor_chain_image_cipher_core (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  in_valid,
    output logic                                 in_stall,
    input  xcic_pkg::in_pixel_t                  in_data,
    output logic                                 out_valid,
    input  wire                                  out_stall,
    output xcic_pkg::out_pixel_t                 out_data,
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire  [xcic_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire  [xcic_pkg::CFG_DATA_W-1:0]      cfg_data
);

    // Configuration registers. Writes are always taken; the user must reconfigure the
    // block only while idle, as the block itself does not enforce this.
    logic [31:0]                     key_seed_reg;
    logic [31:0]                     secret_reg;
    logic [xcic_pkg::COUNT_BITS-1:0] pixel_count_reg;
    logic                            decrypt_reg;

    xcic_pkg::state_t    state_reg;
    xcic_pkg::state_t    state_next;
    logic [xcic_pkg::PIXEL_W-1:0] pix_reg;
    logic [xcic_pkg::PIXEL_W-1:0] pix_next;
    logic [xcic_pkg::PIXEL_W-1:0] chain_reg;
    logic [xcic_pkg::PIXEL_W-1:0] chain_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [xcic_pkg::PIXEL_W-1:0] out_pix_reg;
    logic [xcic_pkg::PIXEL_W-1:0] out_pix_next;

    xcic_pkg::gen_ctrl_t gen_ctrl;
    xcic_pkg::gen_stat_t gen_stat;

    logic                         out_free;
    logic                         in_accept;
    logic                         out_load;
    logic [xcic_pkg::PIXEL_W-1:0] in_pix;
    logic [xcic_pkg::PIXEL_W-1:0] src_pix;
    logic [xcic_pkg::PIXEL_W-1:0] res_pix;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_seed_reg    <= xcic_pkg::KEY_SEED_RESET;
            secret_reg      <= xcic_pkg::SECRET_RESET;
            pixel_count_reg <= xcic_pkg::PIXEL_COUNT_RESET;
            decrypt_reg     <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (xcic_pkg::cfg_index_t'(cfg_index))
                xcic_pkg::REG_KEY_SEED:     key_seed_reg    <= cfg_data[31:0];
                xcic_pkg::REG_SECRET_VALUE: secret_reg      <= cfg_data[31:0];
                xcic_pkg::REG_PIXEL_COUNT:
                    pixel_count_reg <= cfg_data[xcic_pkg::COUNT_BITS-1:0];
                xcic_pkg::REG_DECRYPT_MODE: decrypt_reg     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // The output register parts the two sides: a new pixel may enter in the
    // same cycle that the waiting result is taken.
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = !((state_reg == xcic_pkg::ST_IDLE) && out_free);
    assign in_accept = in_valid && !in_stall;
    assign in_pix    = {in_data.in_red, in_data.in_green, in_data.in_blue};

    // Sequencer. A first pixel is parked in pix_reg while the generator runs
    // its warm-up; a later pixel is whitened in the cycle of its transaction,
    // using the generator word after one more step.
    always_comb
    begin
        state_next   = state_reg;
        pix_next     = pix_reg;
        gen_ctrl     = '0;
        out_load     = 1'b0;
        src_pix      = in_pix;
        res_pix      = in_pix ^ chain_reg ^ gen_stat.next_word[xcic_pkg::PIXEL_W-1:0];
        unique case (state_reg)
            xcic_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (in_data.first_pixel)
                    begin
                        gen_ctrl.load = 1'b1;
                        pix_next      = in_pix;
                        state_next    = xcic_pkg::ST_WARM;
                    end
                    else
                    begin
                        gen_ctrl.advance = 1'b1;
                        out_load         = 1'b1;
                    end
                end
            end
            xcic_pkg::ST_WARM:
            begin
                src_pix = pix_reg;
                res_pix = pix_reg ^ secret_reg[xcic_pkg::PIXEL_W-1:0]
                          ^ gen_stat.word[xcic_pkg::PIXEL_W-1:0];
                if (!gen_stat.busy && out_free)
                begin
                    out_load   = 1'b1;
                    state_next = xcic_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = xcic_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        chain_next     = chain_reg;
        out_pix_next   = out_pix_reg;
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            // Encrypt chains on the ciphertext output, decrypt on the
            // ciphertext input.
            chain_next     = decrypt_reg ? src_pix : res_pix;
            out_pix_next   = res_pix;
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= xcic_pkg::ST_IDLE;
            chain_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chain_reg     <= chain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg     <= pix_next;
        out_pix_reg <= out_pix_next;
    end

    xcic_keygen u_keygen (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (gen_ctrl),
        .seed  (key_seed_reg),
        .count (pixel_count_reg),
        .stat  (gen_stat)
    );

    assign out_valid          = out_valid_reg;
    assign out_data.out_red   = out_pix_reg[23:16];
    assign out_data.out_green = out_pix_reg[15:8];
    assign out_data.out_blue  = out_pix_reg[7:0];

    // The warm-up counter only runs while the sequencer waits on it.
    assert property (@(posedge clk) disable iff (!rst_n)
        gen_stat.busy |-> (state_reg == xcic_pkg::ST_WARM))
        else $error("generator warm-up running outside the warm state");

    // A later pixel yields its result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !in_data.first_pixel) |=> out_valid_reg)
        else $error("later pixel did not reach the output register");

    // A first pixel always moves the sequencer into warm-up.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && in_data.first_pixel) |=> (state_reg == xcic_pkg::ST_WARM))
        else $error("image start did not enter warm-up");

    // No new pixel is taken while a first pixel is pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == xcic_pkg::ST_WARM) |-> in_stall)
        else $error("input accepted during warm-up");

endmodule

`default_nettype wire
